// ----- design/i2ctcs_pkg.sv -----
package i2ctcs_pkg;

  // Result kinds.
  localparam logic [2:0] KIND_START    = 3'd0;
  localparam logic [2:0] KIND_RESTART  = 3'd1;
  localparam logic [2:0] KIND_CONTINUE = 3'd2;
  localparam logic [2:0] KIND_STOP     = 3'd3;
  localparam logic [2:0] KIND_REPORT   = 3'd4;

  // Completion status codes; ST_NONE means no completion has been picked.
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_NOANS   = 3'd1;
  localparam logic [2:0] ST_ARLO    = 3'd2;
  localparam logic [2:0] ST_BERR    = 3'd3;
  localparam logic [2:0] ST_DISCARD = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;
  localparam logic [2:0] ST_NONE    = 3'd7;

  // Request types.
  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_EVENT   = 1'b1;

  // Flag positions within event_flags.
  localparam int FLAG_TCR  = 0;
  localparam int FLAG_TC   = 1;
  localparam int FLAG_NACK = 2;
  localparam int FLAG_ARLO = 3;
  localparam int FLAG_BERR = 4;

  // Source of the payload of a result.
  localparam logic [1:0] SRC_NONE  = 2'd0;
  localparam logic [1:0] SRC_INPUT = 2'd1;
  localparam logic [1:0] SRC_HEAD  = 2'd2;
  localparam logic [1:0] SRC_CHUNK = 2'd3;

  typedef struct packed {
    logic       capture;
    logic       enq_write;
    logic       pop;
    logic       calc1;
    logic       calc_zero;
    logic       calc2;
    logic       off_load;
    logic       off_add;
    logic       emit;
    logic [2:0] kind;
    logic [2:0] status;
    logic [1:0] src;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic       req_type;
    logic       empty_req;
    logic       full;
    logic       count_zero;
    logic       count_one;
    logic [4:0] flags;
    logic       has_chunk;
    logic       out_free;
  } stat_t;

endpackage

// ----- design/i2ctcs_dp.sv -----
module i2ctcs_dp #(
  parameter int QUEUE_DEPTH = 8,
  parameter int MAX_CHUNK   = 255
) (
  input  logic                clk,
  input  logic                rst,
  input  i2ctcs_pkg::cmd_t    cmd,
  output i2ctcs_pkg::stat_t   stat,
  input  logic [119:0]        s_tdata,
  input  logic                s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [63:0]         m_tdata,
  output logic [2:0]          m_tuser,
  output logic                m_tlast
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [15:0] MAXC = 16'(MAX_CHUNK);
  localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);

  // Descriptor stores, read continuously at the head.
  logic [15:0] mem_dat [QUEUE_DEPTH];
  logic [31:0] mem_la  [QUEUE_DEPTH];
  logic [31:0] mem_ra  [QUEUE_DEPTH];
  logic [31:0] mem_sz  [QUEUE_DEPTH];
  logic [15:0] rd_dat;
  logic [31:0] rd_la;
  logic [31:0] rd_ra;
  logic [31:0] rd_sz;

  logic [IW-1:0] head;
  logic [IW-1:0] tail;
  logic [CW-1:0] count;
  logic [16:0]   byte_offset;

  // Captured request.
  logic        req_type;
  logic [7:0]  req_tag;
  logic        req_is_read;
  logic [6:0]  req_saddr;
  logic [31:0] req_la;
  logic [15:0] req_ls;
  logic [31:0] req_ra;
  logic [15:0] req_rs;
  logic [4:0]  req_flags;

  // Chunk calculation, first and second step.
  logic [16:0] c1_off;
  logic [31:0] c1_base;
  logic [15:0] c1_size;
  logic        c1_fin;
  logic [31:0] ch_addr;
  logic [7:0]  ch_len;
  logic        ch_fin;
  logic        ch_has;

  logic [16:0] calc_off;
  logic        calc_lt;
  logic        c2_has;
  logic [15:0] c2_rem;
  logic        c2_big;
  logic        out_free;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type    <= s_tuser;
      req_tag     <= s_tdata[7:0];
      req_is_read <= s_tdata[8];
      req_saddr   <= s_tdata[15:9];
      req_la      <= s_tdata[47:16];
      req_ls      <= s_tdata[63:48];
      req_ra      <= s_tdata[95:64];
      req_rs      <= s_tdata[111:96];
      req_flags   <= s_tdata[116:112];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enq_write) begin
      mem_dat[tail] <= {req_is_read, req_saddr, req_tag};
      mem_la[tail]  <= req_la;
      mem_ra[tail]  <= req_ra;
      mem_sz[tail]  <= {req_rs, req_ls};
    end
    rd_dat <= mem_dat[head];
    rd_la  <= mem_la[head];
    rd_ra  <= mem_ra[head];
    rd_sz  <= mem_sz[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.enq_write) begin
      tail  <= (tail == LAST_IDX) ? '0 : tail + 1'b1;
      count <= count + 1'b1;
    end else if (cmd.pop) begin
      head  <= (head == LAST_IDX) ? '0 : head + 1'b1;
      count <= count - 1'b1;
    end
  end

  // The stream runs through the local buffer first, then the remote one.
  always_comb begin
    calc_off = cmd.calc_zero ? 17'd0 : byte_offset;
    calc_lt  = calc_off < {1'b0, rd_sz[15:0]};
    c2_has   = c1_off < {1'b0, c1_size};
    c2_rem   = c1_size - c1_off[15:0];
    c2_big   = c2_rem > MAXC;
  end

  always_ff @(posedge clk) begin
    if (cmd.calc1) begin
      c1_off  <= calc_lt ? calc_off : calc_off - {1'b0, rd_sz[15:0]};
      c1_base <= calc_lt ? rd_la : rd_ra;
      c1_size <= calc_lt ? rd_sz[15:0] : rd_sz[31:16];
      c1_fin  <= calc_lt ? (rd_sz[31:16] == 16'd0) : 1'b1;
    end
    if (cmd.calc2) begin
      ch_has  <= c2_has;
      ch_len  <= c2_big ? MAXC[7:0] : c2_rem[7:0];
      ch_fin  <= c2_big ? 1'b0 : c1_fin;
      ch_addr <= c1_base + 32'(c1_off);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
    end else if (cmd.off_load) begin
      byte_offset <= ch_has ? 17'(ch_len) : 17'd0;
    end else if (cmd.off_add) begin
      byte_offset <= byte_offset + 17'(ch_len);
    end
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tuser <= cmd.kind;
      m_tlast <= cmd.last;
      case (cmd.src)
        i2ctcs_pkg::SRC_INPUT: begin
          m_tdata <= {4'd0, cmd.status, 41'd0, req_saddr, req_is_read, req_tag};
        end
        i2ctcs_pkg::SRC_HEAD: begin
          m_tdata <= {4'd0, cmd.status, 41'd0, rd_dat[14:8], rd_dat[15], rd_dat[7:0]};
        end
        i2ctcs_pkg::SRC_CHUNK: begin
          m_tdata <= {4'd0, cmd.status, ch_has & ~ch_fin,
                      ch_has ? ch_len : 8'd0, ch_has ? ch_addr : 32'd0,
                      rd_dat[14:8], rd_dat[15], rd_dat[7:0]};
        end
        default: begin
          m_tdata <= '0;
        end
      endcase
    end
  end

  always_comb begin
    stat.req_type   = req_type;
    stat.empty_req  = (req_ls == 16'd0) && (req_rs == 16'd0);
    stat.full       = count == CW'(QUEUE_DEPTH);
    stat.count_zero = count == '0;
    stat.count_one  = count == CW'(1);
    stat.flags      = req_flags;
    stat.has_chunk  = ch_has;
    stat.out_free   = out_free;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> count != '0)
    else $error("pop from an empty queue");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    cmd.enq_write |-> count < CW'(QUEUE_DEPTH))
    else $error("write into a full queue");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result loaded over one still waiting");

endmodule

// ----- design/i2ctcs_ctrl.sv -----
module i2ctcs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  i2ctcs_pkg::stat_t  stat,
  output i2ctcs_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_READ    = 3'd2;
  localparam logic [2:0] S_CALC1   = 3'd3;
  localparam logic [2:0] S_CALC2   = 3'd4;
  localparam logic [2:0] S_CHUNK   = 3'd5;
  localparam logic [2:0] S_RESOLVE = 3'd6;
  localparam logic [2:0] S_STOP    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       mode_start;
  logic       mode_start_next;
  logic [2:0] start_kind;
  logic [2:0] start_kind_next;
  logic [2:0] st;
  logic [2:0] st_next;
  logic [2:0] flag_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode_start <= 1'b0;
      start_kind <= i2ctcs_pkg::KIND_START;
      st         <= i2ctcs_pkg::ST_NONE;
    end else begin
      state      <= state_next;
      mode_start <= mode_start_next;
      start_kind <= start_kind_next;
      st         <= st_next;
    end
  end

  // The highest flag present wins, as later flags override earlier ones.
  always_comb begin
    if (stat.flags[i2ctcs_pkg::FLAG_BERR]) begin
      flag_st = i2ctcs_pkg::ST_BERR;
    end else if (stat.flags[i2ctcs_pkg::FLAG_ARLO]) begin
      flag_st = i2ctcs_pkg::ST_ARLO;
    end else if (stat.flags[i2ctcs_pkg::FLAG_NACK]) begin
      flag_st = i2ctcs_pkg::ST_NOANS;
    end else if (stat.flags[i2ctcs_pkg::FLAG_TC]) begin
      flag_st = i2ctcs_pkg::ST_DONE;
    end else begin
      flag_st = i2ctcs_pkg::ST_NONE;
    end
  end

  always_comb begin
    state_next      = state;
    mode_start_next = mode_start;
    start_kind_next = start_kind;
    st_next         = st;
    cmd             = '0;
    s_tready        = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.out_free) begin
          if (stat.req_type == i2ctcs_pkg::REQ_ENQUEUE) begin
            if (stat.empty_req || stat.full) begin
              cmd.emit   = 1'b1;
              cmd.src    = i2ctcs_pkg::SRC_INPUT;
              cmd.kind   = i2ctcs_pkg::KIND_REPORT;
              cmd.status = stat.empty_req ? i2ctcs_pkg::ST_DISCARD : i2ctcs_pkg::ST_FULL;
              cmd.last   = 1'b1;
              state_next = S_IDLE;
            end else begin
              cmd.enq_write = 1'b1;
              if (stat.count_zero) begin
                mode_start_next = 1'b1;
                start_kind_next = i2ctcs_pkg::KIND_START;
                state_next      = S_READ;
              end else begin
                state_next = S_IDLE;
              end
            end
          end else if (stat.flags[i2ctcs_pkg::FLAG_TCR] && !stat.count_zero) begin
            mode_start_next = 1'b0;
            state_next      = S_READ;
          end else if (flag_st != i2ctcs_pkg::ST_NONE) begin
            st_next    = flag_st;
            state_next = S_RESOLVE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_READ: begin
        state_next = S_CALC1;
      end
      S_CALC1: begin
        cmd.calc1     = 1'b1;
        cmd.calc_zero = mode_start;
        state_next    = S_CALC2;
      end
      S_CALC2: begin
        cmd.calc2  = 1'b1;
        state_next = S_CHUNK;
      end
      S_CHUNK: begin
        if (stat.out_free) begin
          if (mode_start) begin
            cmd.emit     = 1'b1;
            cmd.src      = i2ctcs_pkg::SRC_CHUNK;
            cmd.kind     = start_kind;
            cmd.status   = i2ctcs_pkg::ST_DONE;
            cmd.last     = 1'b1;
            cmd.off_load = 1'b1;
            state_next   = S_IDLE;
          end else if (stat.has_chunk) begin
            cmd.emit    = 1'b1;
            cmd.src     = i2ctcs_pkg::SRC_CHUNK;
            cmd.kind    = i2ctcs_pkg::KIND_CONTINUE;
            cmd.status  = i2ctcs_pkg::ST_DONE;
            cmd.last    = flag_st == i2ctcs_pkg::ST_NONE;
            cmd.off_add = 1'b1;
            if (flag_st == i2ctcs_pkg::ST_NONE) begin
              state_next = S_IDLE;
            end else begin
              st_next    = flag_st;
              state_next = S_RESOLVE;
            end
          end else begin
            // Nothing left to send counts as a clean finish unless a flag says otherwise.
            st_next    = (flag_st == i2ctcs_pkg::ST_NONE) ? i2ctcs_pkg::ST_DONE : flag_st;
            state_next = S_RESOLVE;
          end
        end
      end
      S_RESOLVE: begin
        if (stat.out_free) begin
          if (!stat.count_zero) begin
            cmd.emit   = 1'b1;
            cmd.src    = i2ctcs_pkg::SRC_HEAD;
            cmd.kind   = i2ctcs_pkg::KIND_REPORT;
            cmd.status = st;
            cmd.pop    = 1'b1;
            cmd.last   = stat.count_one && (st != i2ctcs_pkg::ST_DONE);
            if (!stat.count_one) begin
              mode_start_next = 1'b1;
              start_kind_next = (st == i2ctcs_pkg::ST_DONE) ? i2ctcs_pkg::KIND_RESTART
                                                            : i2ctcs_pkg::KIND_START;
              state_next      = S_READ;
            end else if (st == i2ctcs_pkg::ST_DONE) begin
              state_next = S_STOP;
            end else begin
              state_next = S_IDLE;
            end
          end else if (st == i2ctcs_pkg::ST_DONE) begin
            cmd.emit   = 1'b1;
            cmd.src    = i2ctcs_pkg::SRC_NONE;
            cmd.kind   = i2ctcs_pkg::KIND_STOP;
            cmd.status = i2ctcs_pkg::ST_DONE;
            cmd.last   = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_STOP: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.src    = i2ctcs_pkg::SRC_NONE;
          cmd.kind   = i2ctcs_pkg::KIND_STOP;
          cmd.status = i2ctcs_pkg::ST_DONE;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/i2c_transfer_chunk_sequencer_unit.sv -----
// Channel   Direction  Handshake            Contents
// s_*       in         s_tvalid/s_tready    enqueue request or controller flag event
// m_*       out        m_tvalid/m_tready    start, restart, continue, stop or report
//
// One request is handled at a time by the sequencer state machine; s_tready is
// high only while it waits for a request. A start goes through the head-entry
// memory read and the two-step chunk calculation before its result is loaded,
// and an event that continues, reports and restarts goes through them twice.
// A result waiting in the output register holds the sequencer until it is
// taken. Reset is synchronous and empties the queue at once.
module i2c_transfer_chunk_sequencer_unit #(
  parameter int QUEUE_DEPTH = 8,
  parameter int MAX_CHUNK   = 255
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tag, is_read, slave_address, local_addr, local_len, remote_addr,
  // remote_len, event_flags, zero fill
  input  logic [119:0] s_tdata,
  // req_type
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_tag, out_is_read, out_slave_address, dma_addr, chunk_len, reload,
  // status, zero fill
  output logic [63:0]  m_tdata,
  // out_kind
  output logic [2:0]   m_tuser,
  output logic         m_tlast
);

  i2ctcs_pkg::cmd_t  cmd;
  i2ctcs_pkg::stat_t stat;

  i2ctcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  i2ctcs_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_CHUNK   (MAX_CHUNK)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- test/i2c_sequencer_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of the sequencer, keeps its own copy of the transaction
// queue and works out the results of every accepted request.
module i2c_sequencer_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [119:0] s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,
  input  logic [2:0]   m_tuser,
  input  logic         m_tlast,
  output int           fail_count,
  output int           awaited_count,
  output int           result_count
);

  localparam int DEPTH     = 8;
  localparam int MAX_CHUNK = 255;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tag;
    logic        rd;
    logic [6:0]  sa;
    logic [31:0] addr;
    logic [7:0]  len;
    logic        reload;
    logic [2:0]  status;
    logic        last;
  } bus_result_t;

  // Shadow of the transaction queue.
  logic [7:0]  q_tag   [DEPTH];
  logic        q_rd    [DEPTH];
  logic [6:0]  q_sa    [DEPTH];
  logic [31:0] q_laddr [DEPTH];
  logic [15:0] q_lsize [DEPTH];
  logic [31:0] q_raddr [DEPTH];
  logic [15:0] q_rsize [DEPTH];
  int          q_head;
  int          q_count;
  logic [16:0] bytes_issued;

  bus_result_t awaited[$];

  function automatic bus_result_t mk(input logic [2:0] kind, input logic [7:0] tag,
                                     input logic rd, input logic [6:0] sa,
                                     input logic [31:0] addr, input logic [7:0] len,
                                     input logic reload, input logic [2:0] status);
    bus_result_t r;
    r = '{kind: kind, tag: tag, rd: rd, sa: sa, addr: addr, len: len,
          reload: reload, status: status, last: 1'b0};
    return r;
  endfunction

  function automatic string describe(input bus_result_t r);
    return $sformatf("kind=%0d tag=%02h rd=%0b sa=%02h addr=%08h len=%0d reload=%0b st=%0d last=%0b",
                     r.kind, r.tag, r.rd, r.sa, r.addr, r.len, r.reload, r.status, r.last);
  endfunction

  // The two buffers of the head form one byte stream; find the chunk at offset off.
  function automatic logic chunk_of_head(input logic [16:0] off, output logic [31:0] a,
                                         output logic [7:0] l, output logic fin);
    logic [16:0] ls, rs, size, o;
    logic [31:0] base;
    ls = {1'b0, q_lsize[q_head]};
    rs = {1'b0, q_rsize[q_head]};
    o  = off;
    a  = '0;
    l  = '0;
    if (o < ls) begin
      base = q_laddr[q_head];
      size = ls;
      fin  = (rs == 0);
    end else begin
      o    = o - ls;
      base = q_raddr[q_head];
      size = rs;
      fin  = 1'b1;
    end
    if (o >= size) return 1'b0;
    size = size - o;
    if (size > MAX_CHUNK) begin
      size = 17'(MAX_CHUNK);
      fin  = 1'b0;
    end
    a = base + {15'd0, o};
    l = size[7:0];
    return 1'b1;
  endfunction

  function automatic bus_result_t head_result(input logic [2:0] kind, input logic [31:0] a,
                                              input logic [7:0] l, input logic reload,
                                              input logic [2:0] status);
    return mk(kind, q_tag[q_head], q_rd[q_head], q_sa[q_head], a, l, reload, status);
  endfunction

  function automatic bus_result_t start_of_head(input logic restart);
    logic [31:0] a;
    logic [7:0]  l;
    logic        fin;
    if (!chunk_of_head('0, a, l, fin)) begin
      a   = '0;
      l   = '0;
      fin = 1'b1;
    end
    bytes_issued = {9'd0, l};
    // Start and restart carry a zero status.
    return head_result(restart ? i2ctcs_pkg::KIND_RESTART : i2ctcs_pkg::KIND_START,
                       a, l, !fin, i2ctcs_pkg::ST_DONE);
  endfunction

  task automatic predict_request(input logic typ, input logic [119:0] d);
    bus_result_t batch[$];
    logic [31:0] a;
    logic [7:0]  l;
    logic        fin;
    logic [2:0]  st;
    logic [4:0]  f;
    logic [15:0] ls, rs;
    int          slot;
    logic        was_empty;
    if (typ == i2ctcs_pkg::REQ_ENQUEUE) begin
      ls = d[63:48];
      rs = d[111:96];
      if (ls == 0 && rs == 0) begin
        batch.push_back(mk(i2ctcs_pkg::KIND_REPORT, d[7:0], d[8], d[15:9], '0, '0, 1'b0,
                           i2ctcs_pkg::ST_DISCARD));
      end else if (q_count >= DEPTH) begin
        batch.push_back(mk(i2ctcs_pkg::KIND_REPORT, d[7:0], d[8], d[15:9], '0, '0, 1'b0,
                           i2ctcs_pkg::ST_FULL));
      end else begin
        slot          = (q_head + q_count) % DEPTH;
        q_tag[slot]   = d[7:0];
        q_rd[slot]    = d[8];
        q_sa[slot]    = d[15:9];
        q_laddr[slot] = d[47:16];
        q_lsize[slot] = ls;
        q_raddr[slot] = d[95:64];
        q_rsize[slot] = rs;
        was_empty     = (q_count == 0);
        q_count++;
        if (was_empty) batch.push_back(start_of_head(1'b0));
      end
    end else begin
      f  = d[116:112];
      st = i2ctcs_pkg::ST_NONE;
      if (f[i2ctcs_pkg::FLAG_TCR] && q_count != 0) begin
        if (chunk_of_head(bytes_issued, a, l, fin)) begin
          bytes_issued = bytes_issued + {9'd0, l};
          batch.push_back(head_result(i2ctcs_pkg::KIND_CONTINUE, a, l, !fin,
                                      i2ctcs_pkg::ST_DONE));
        end else begin
          // Nothing left to move: the transfer is complete.
          st = i2ctcs_pkg::ST_DONE;
        end
      end
      if (f[i2ctcs_pkg::FLAG_TC])   st = i2ctcs_pkg::ST_DONE;
      if (f[i2ctcs_pkg::FLAG_NACK]) st = i2ctcs_pkg::ST_NOANS;
      if (f[i2ctcs_pkg::FLAG_ARLO]) st = i2ctcs_pkg::ST_ARLO;
      if (f[i2ctcs_pkg::FLAG_BERR]) st = i2ctcs_pkg::ST_BERR;
      if (st != i2ctcs_pkg::ST_NONE) begin
        if (q_count != 0) begin
          batch.push_back(head_result(i2ctcs_pkg::KIND_REPORT, '0, '0, 1'b0, st));
          q_head = (q_head + 1) % DEPTH;
          q_count--;
        end
        if (q_count != 0)
          batch.push_back(start_of_head(st == i2ctcs_pkg::ST_DONE));
        else if (st == i2ctcs_pkg::ST_DONE)
          batch.push_back(mk(i2ctcs_pkg::KIND_STOP, '0, 1'b0, '0, '0, '0, 1'b0,
                             i2ctcs_pkg::ST_DONE));
      end
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) awaited.push_back(batch[i]);
  endtask

  always @(posedge clk) begin
    bus_result_t got, want;
    if (rst) begin
      awaited.delete();
      q_head       = 0;
      q_count      = 0;
      bytes_issued = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{kind: m_tuser, tag: m_tdata[7:0], rd: m_tdata[8], sa: m_tdata[15:9],
                addr: m_tdata[47:16], len: m_tdata[55:48], reload: m_tdata[56],
                status: m_tdata[59:57], last: m_tlast};
        result_count++;
        if (awaited.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result %s", $realtime, describe(got));
        end else begin
          want = awaited.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result %0d mismatch", $realtime, result_count);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
      if (s_tvalid && s_tready) predict_request(s_tuser, s_tdata);
    end
    awaited_count = awaited.size();
  end

endmodule

// ----- test/tb_i2c_transfer_chunk_sequencer_unit.sv -----
`timescale 1ns / 100ps

module tb_i2c_transfer_chunk_sequencer_unit;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [119:0] s_tdata  = '0;
  logic         s_tuser  = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;

  int fail_count, awaited_count, result_count;
  int n_enq = 0, n_evt = 0, n_pause = 0;
  bit idle_free = 1'b0;

  i2c_transfer_chunk_sequencer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  i2c_sequencer_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .fail_count    (fail_count),
    .awaited_count (awaited_count),
    .result_count  (result_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("timed out with %0d results still awaited", awaited_count);
    $display("tb_i2c_transfer_chunk_sequencer_unit: done, errors");
    $finish;
  end

  // Receiver: a random stall before each result, none while idle_free is set.
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = idle_free ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_req(input logic typ, input logic [119:0] d);
    int gap;
    gap = idle_free ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= typ;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Unused fields of a request carry random junk, which the block must ignore.
  task automatic enq(input logic [7:0] tag, input logic rd, input logic [6:0] sa,
                     input logic [31:0] la, input logic [15:0] ls,
                     input logic [31:0] ra, input logic [15:0] rs);
    logic [4:0] junk;
    junk = 5'($urandom_range(0, 31));
    n_enq++;
    send_req(i2ctcs_pkg::REQ_ENQUEUE, {3'd0, junk, rs, ra, ls, la, sa, rd, tag});
  endtask

  task automatic evt(input logic [4:0] flags);
    logic [111:0] junk;
    junk = 112'({$urandom, $urandom, $urandom, $urandom});
    n_evt++;
    send_req(i2ctcs_pkg::REQ_EVENT, {3'd0, flags, junk});
  endtask

  // Hold the sender back until every predicted result has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    n_pause++;
    @(negedge clk);
    while (awaited_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_size();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1, 2:    return 16'($urandom_range(0, 65535));
      3:       return 16'd255;
      4:       return 16'd256;
      default: return 16'($urandom_range(1, 600));
    endcase
  endfunction

  initial begin
    int r;
    logic [4:0] fl;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Events against an empty queue.
    evt(5'd0);
    evt(5'b1 << i2ctcs_pkg::FLAG_TCR);
    evt(5'b1 << i2ctcs_pkg::FLAG_NACK);
    evt(5'b1 << i2ctcs_pkg::FLAG_TC);
    // Empty transaction is discarded.
    enq(8'h00, 1'b0, 7'h00, 32'h0, 16'd0, 32'h0, 16'd0);
    // Stream across both buffers with address wrap, walked to its end by TCR.
    enq(8'hFF, 1'b1, 7'h7F, 32'hFFFF_FF00, 16'd300, 32'hFFFF_FFFF, 16'd2);
    evt(5'b1 << i2ctcs_pkg::FLAG_TCR);
    evt(5'b1 << i2ctcs_pkg::FLAG_TCR);
    evt(5'b1 << i2ctcs_pkg::FLAG_TCR);
    // Only a remote buffer, then fill the queue and overflow it.
    enq(8'h01, 1'b0, 7'h55, 32'h1000_0000, 16'd0, 32'hABCD_0000, 16'd10);
    for (int i = 2; i <= 8; i++)
      enq(i[7:0], i[0], 7'(i * 9), $urandom, 16'(i * 64 - 1), $urandom, 16'(i % 3));
    enq(8'h09, 1'b1, 7'h2A, 32'h0, 16'd1, 32'h0, 16'd1);
    // Every flag at once: bus error wins.
    evt(5'h1F);
    evt(5'b1 << i2ctcs_pkg::FLAG_NACK);
    evt(5'b1 << i2ctcs_pkg::FLAG_ARLO);
    evt((5'b1 << i2ctcs_pkg::FLAG_TCR) | (5'b1 << i2ctcs_pkg::FLAG_TC));
    enq(8'h0A, 1'b0, 7'h01, 32'h8000_0001, 16'hFFFF, 32'h7FFF_FFFE, 16'hFFFF);
    drain();

    for (int n = 0; n < 87; n++) begin
      if (n % 12 == 0) idle_free = ($urandom_range(0, 3) == 0);
      if (n % 29 == 28) drain();
      r = $urandom_range(0, 99);
      if (r < 32) begin
        enq(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
            7'($urandom_range(0, 127)), $urandom, rand_size(), $urandom, rand_size());
      end else if (r < 72) begin
        evt(5'b1 << i2ctcs_pkg::FLAG_TCR);
      end else if (r < 82) begin
        fl = 5'b1 << i2ctcs_pkg::FLAG_TC;
        if ($urandom_range(0, 1)) fl[i2ctcs_pkg::FLAG_TCR] = 1'b1;
        evt(fl);
      end else if (r < 90) begin
        fl = 5'b1 << $urandom_range(i2ctcs_pkg::FLAG_NACK, i2ctcs_pkg::FLAG_BERR);
        if ($urandom_range(0, 1)) fl[i2ctcs_pkg::FLAG_TCR] = 1'b1;
        evt(fl);
      end else begin
        evt(5'($urandom_range(0, 31)));
      end
    end
    idle_free = 1'b0;
    drain();
    repeat (100) @(posedge clk);
    @(negedge clk);

    $display("sent %0d enqueue and %0d flag event requests, %0d results compared",
             n_enq, n_evt, result_count);
    $display("sender held back until drained %0d times, %0d mismatches",
             n_pause, fail_count);
    if (fail_count == 0 && awaited_count == 0)
      $display("tb_i2c_transfer_chunk_sequencer_unit: done, clean");
    else
      $display("tb_i2c_transfer_chunk_sequencer_unit: done, errors");
    $finish;
  end

endmodule
